// ----- src/byte_stack_with_rotate_macros.svh -----
// assertion helpers used by the stack datapath
`ifndef BYTE_STACK_WITH_ROTATE_MACROS_SVH
`define BYTE_STACK_WITH_ROTATE_MACROS_SVH

// condition must hold at every clock edge outside reset
`define BSR_ASSERT_ALWAYS(lbl, clk_i, rstn_i, cond, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (cond)) \
		else $error(msg);

// consequent must hold in the cycle of the antecedent
`define BSR_ASSERT_IMPLY(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- src/bsr_pkg.sv -----
package bsr_pkg;

	// field widths
	localparam int CMD_W  = 3;
	localparam int VAL_W  = 8;
	localparam int CNT_W  = 8;
	localparam int CAP_W  = 5;
	localparam int FILL_W = 5;
	localparam int DATA_W = 32;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PEEK     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DUP      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ROT_UP   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_ROT_DOWN = 3'd5;

	// register map
	localparam int         PADDR_W   = 3;
	localparam logic [0:0] CAP_IDX   = 1'b0;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_BADCOUNT = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POP_WAIT,
		S_PEEK_WAIT,
		S_DUP_WAIT,
		S_ROT_HOLD,
		S_ROT_RD,
		S_ROT_WR
	} state_t;

	// read address source
	typedef enum logic [1:0] {
		RD_TOP,
		RD_BASE,
		RD_STEP
	} rd_sel_t;

	// write address and data source
	typedef enum logic [2:0] {
		WR_NONE,
		WR_PUSH,
		WR_DUP,
		WR_SHIFT,
		WR_HOLD
	} wr_sel_t;

	typedef enum logic [1:0] {
		OCC_KEEP,
		OCC_INC,
		OCC_DEC
	} occ_op_t;

	// commands from controller to datapath
	typedef struct packed {
		logic    mem_re;
		rd_sel_t rd_sel;
		wr_sel_t wr_sel;
		occ_op_t occ_op;
		logic    load_rot;
		logic    step_ptr;
		logic    hold;
		logic    finish;
		status_t st;
		logic    show_data;
	} ctl_t;

	// status from datapath to controller
	typedef struct packed {
		logic empty;
		logic full;
		logic bad_count;
		logic at_end;
		logic out_busy;
	} sts_t;

endpackage

// ----- src/bsr_ctrl.sv -----
module bsr_ctrl import bsr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] cmd,
	input  sts_t             sts,
	output logic             in_stall,
	output ctl_t             ctl
);

	state_t state_q;
	state_t state_next;
	logic   accept;

	// one item in flight, and the result register must be free
	assign in_stall = (state_q != S_IDLE) || sts.out_busy;
	assign accept   = in_valid && !in_stall;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// next state and datapath commands
	always_comb begin
		state_next    = state_q;
		ctl           = '0;
		ctl.rd_sel    = RD_TOP;
		ctl.wr_sel    = WR_NONE;
		ctl.occ_op    = OCC_KEEP;
		ctl.st        = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_PUSH: begin
							ctl.finish = 1'b1;
							if (sts.full) begin
								ctl.st = ST_FULL;
							end else begin
								ctl.wr_sel = WR_PUSH;
								ctl.occ_op = OCC_INC;
							end
						end
						CMD_POP, CMD_PEEK: begin
							if (sts.empty) begin
								ctl.finish = 1'b1;
								ctl.st     = ST_EMPTY;
							end else begin
								ctl.mem_re = 1'b1;
								state_next = (cmd == CMD_POP) ? S_POP_WAIT : S_PEEK_WAIT;
							end
						end
						CMD_DUP: begin
							if (sts.empty) begin
								ctl.finish = 1'b1;
								ctl.st     = ST_EMPTY;
							end else if (sts.full) begin
								ctl.finish = 1'b1;
								ctl.st     = ST_FULL;
							end else begin
								ctl.mem_re = 1'b1;
								state_next = S_DUP_WAIT;
							end
						end
						CMD_ROT_UP, CMD_ROT_DOWN: begin
							if (sts.bad_count) begin
								ctl.finish = 1'b1;
								ctl.st     = ST_BADCOUNT;
							end else begin
								// fetch the entry that travels to the far end
								ctl.mem_re   = 1'b1;
								ctl.rd_sel   = (cmd == CMD_ROT_UP) ? RD_TOP : RD_BASE;
								ctl.load_rot = 1'b1;
								state_next   = S_ROT_HOLD;
							end
						end
						default: begin
							ctl.finish = 1'b1;
						end
					endcase
				end
			end
			S_POP_WAIT: begin
				ctl.finish    = 1'b1;
				ctl.show_data = 1'b1;
				ctl.occ_op    = OCC_DEC;
				state_next    = S_IDLE;
			end
			S_PEEK_WAIT: begin
				ctl.finish    = 1'b1;
				ctl.show_data = 1'b1;
				state_next    = S_IDLE;
			end
			S_DUP_WAIT: begin
				ctl.wr_sel = WR_DUP;
				ctl.occ_op = OCC_INC;
				ctl.finish = 1'b1;
				state_next = S_IDLE;
			end
			S_ROT_HOLD: begin
				ctl.hold   = 1'b1;
				state_next = S_ROT_RD;
			end
			S_ROT_RD: begin
				if (sts.at_end) begin
					// travelling entry lands in the freed place
					ctl.wr_sel = WR_HOLD;
					ctl.finish = 1'b1;
					state_next = S_IDLE;
				end else begin
					ctl.mem_re = 1'b1;
					ctl.rd_sel = RD_STEP;
					state_next = S_ROT_WR;
				end
			end
			S_ROT_WR: begin
				ctl.wr_sel   = WR_SHIFT;
				ctl.step_ptr = 1'b1;
				state_next   = S_ROT_RD;
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

endmodule

// ----- src/bsr_dpath.sv -----
`include "byte_stack_with_rotate_macros.svh"

module bsr_dpath import bsr_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [VAL_W-1:0]  push_value,
	input  logic [CNT_W-1:0]  rotate_count,
	input  logic [CAP_W-1:0]  cap,
	input  ctl_t              ctl,
	input  logic              out_stall,
	output sts_t              sts,
	output logic              out_valid,
	output logic [1:0]        status,
	output logic              has_data,
	output logic [VAL_W-1:0]  read_value,
	output logic [FILL_W-1:0] fill
);

	localparam int IDX_W = $clog2(DEPTH);
	localparam int OCC_W = $clog2(DEPTH + 1);
	localparam int CW    = OCC_W + CNT_W;

	// stack storage
	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] occ_next;
	logic [IDX_W-1:0] ptr_q;
	logic [IDX_W-1:0] end_q;
	logic             dir_up_q;
	logic [VAL_W-1:0] hold_q;

	logic             out_valid_q;
	status_t          status_q;
	logic             has_data_q;
	logic [VAL_W-1:0] read_value_q;
	logic [FILL_W-1:0] fill_q;

	logic [CW-1:0]    occ_x;
	logic [CW-1:0]    cap_x;
	logic [CW-1:0]    n_x;
	logic [CW-1:0]    eff_x;
	logic [CW-1:0]    base_x;
	logic [IDX_W-1:0] top_idx;
	logic [IDX_W-1:0] base_idx;
	logic [IDX_W-1:0] occ_idx;
	logic [IDX_W-1:0] raddr;
	logic [IDX_W-1:0] waddr;
	logic [VAL_W-1:0] wdata;
	logic             wen;
	logic [OCC_W+FILL_W-1:0] occ_ext;

	// capacity clamped to 1..DEPTH
	assign occ_x = CW'(occ_q);
	assign cap_x = CW'(cap);
	assign n_x   = CW'(rotate_count);
	assign eff_x = (cap_x == '0) ? CW'(1) :
		((cap_x > CW'(DEPTH)) ? CW'(DEPTH) : cap_x);

	// stack positions
	assign top_idx  = IDX_W'(occ_q - OCC_W'(1));
	assign base_x   = occ_x - n_x;
	assign base_idx = base_x[IDX_W-1:0];
	assign occ_idx  = occ_q[IDX_W-1:0];

	// status to the controller
	assign sts.empty     = (occ_q == '0);
	assign sts.full      = (occ_x >= eff_x);
	assign sts.bad_count = (n_x == '0) || (n_x > occ_x);
	assign sts.at_end    = (ptr_q == end_q);
	assign sts.out_busy  = out_valid_q && out_stall;

	// read address select
	always_comb begin
		case (ctl.rd_sel)
			RD_TOP:  raddr = top_idx;
			RD_BASE: raddr = base_idx;
			RD_STEP: raddr = dir_up_q ? (ptr_q - IDX_W'(1)) : (ptr_q + IDX_W'(1));
			default: raddr = top_idx;
		endcase
	end

	// write port select
	always_comb begin
		wen   = 1'b1;
		waddr = occ_idx;
		wdata = rdata_q;
		case (ctl.wr_sel)
			WR_NONE: wen = 1'b0;
			WR_PUSH: wdata = push_value;
			WR_DUP: begin
				waddr = occ_idx;
			end
			WR_SHIFT: waddr = ptr_q;
			WR_HOLD: begin
				waddr = ptr_q;
				wdata = hold_q;
			end
			default: wen = 1'b0;
		endcase
	end

	// occupancy update
	always_comb begin
		case (ctl.occ_op)
			OCC_INC: occ_next = occ_q + OCC_W'(1);
			OCC_DEC: occ_next = occ_q - OCC_W'(1);
			default: occ_next = occ_q;
		endcase
	end

	assign occ_ext = {{FILL_W{1'b0}}, occ_next};

	// memory write
	always_ff @(posedge clk) begin
		if (wen) begin
			mem[waddr] <= wdata;
		end
	end

	// memory read, registered
	always_ff @(posedge clk) begin
		if (ctl.mem_re) begin
			rdata_q <= mem[raddr];
		end
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_next;
		end
	end

	// rotate pointer and travelling entry
	always_ff @(posedge clk) begin
		if (ctl.load_rot) begin
			dir_up_q <= (cmd == CMD_ROT_UP);
			ptr_q    <= (cmd == CMD_ROT_UP) ? top_idx : base_idx;
			end_q    <= (cmd == CMD_ROT_UP) ? base_idx : top_idx;
		end else if (ctl.step_ptr) begin
			ptr_q <= dir_up_q ? (ptr_q - IDX_W'(1)) : (ptr_q + IDX_W'(1));
		end
		if (ctl.hold) begin
			hold_q <= rdata_q;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			status_q     <= ctl.st;
			has_data_q   <= ctl.show_data;
			read_value_q <= ctl.show_data ? rdata_q : '0;
			fill_q       <= occ_ext[FILL_W-1:0];
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign has_data   = has_data_q;
	assign read_value = read_value_q;
	assign fill       = fill_q;

	// checks
	`BSR_ASSERT_ALWAYS(a_occ_bound, clk, arst_n, occ_q <= OCC_W'(DEPTH), "occupancy above depth")
	`BSR_ASSERT_IMPLY(a_grow_room, clk, arst_n, ctl.wr_sel == WR_PUSH || ctl.wr_sel == WR_DUP, occ_x < eff_x, "stack grown past capacity")
	`BSR_ASSERT_IMPLY(a_out_hold, clk, arst_n, out_valid_q && out_stall, !ctl.finish, "result overwritten while stalled")
	`BSR_ASSERT_IMPLY(a_ptr_in_fill, clk, arst_n, ctl.step_ptr, CW'(ptr_q) < occ_x, "rotate pointer outside the fill")

endmodule

// ----- src/byte_stack_with_rotate.sv -----
// Byte-wide LIFO stack with push, pop, peek, duplicate and rotate of the top n entries,
// held in a single-port-write, registered-read memory of DEPTH bytes driven by a small
// sequencer. One item is worked at a time and gives one result: push, every rejected
// command and unused codes finish when taken, pop, peek and duplicate wait on the read,
// and an accepted rotate of n entries holds the travelling entry, moves each other by a
// read and a write, then writes the held one to the freed place. The result sits in
// an output register; the next item is taken once the current one is done and its result
// is taken or being taken. Capacity (register 0, byte address 0) is clamped to 1..DEPTH;
// lowering it below the fill drops nothing. Entries need no clearing after reset.
module byte_stack_with_rotate import bsr_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [VAL_W-1:0]   push_value,
	input  logic [CNT_W-1:0]   rotate_count,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         status,
	output logic               has_data,
	output logic [VAL_W-1:0]   read_value,
	output logic [FILL_W-1:0]  fill,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready
);

	logic [CAP_W-1:0] cap_q;
	logic [0:0]       reg_idx;
	logic             cfg_wr;
	ctl_t             ctl;
	sts_t             sts;

	// register decode
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && (reg_idx == CAP_IDX);
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == CAP_IDX) ? DATA_W'(cap_q) : '0;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	bsr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.cmd      (cmd),
		.sts      (sts),
		.in_stall (in_stall),
		.ctl      (ctl)
	);

	bsr_dpath #(
		.DEPTH (DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.push_value   (push_value),
		.rotate_count (rotate_count),
		.cap          (cap_q),
		.ctl          (ctl),
		.out_stall    (out_stall),
		.sts          (sts),
		.out_valid    (out_valid),
		.status       (status),
		.has_data     (has_data),
		.read_value   (read_value),
		.fill         (fill)
	);

endmodule

// ----- tb/byte_stack_with_rotate_checker.sv -----
`timescale 1ns / 100ps

module byte_stack_with_rotate_checker import bsr_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [CMD_W-1:0]   cmd,
	input  logic [VAL_W-1:0]   push_value,
	input  logic [CNT_W-1:0]   rotate_count,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         status,
	input  logic               has_data,
	input  logic [VAL_W-1:0]   read_value,
	input  logic [FILL_W-1:0]  fill,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output int                 mismatches,
	output int                 outstanding,
	output int                 stack_fill,
	output int                 commands_seen,
	output int                 results_checked,
	output int                 full_reports,
	output int                 empty_reports,
	output int                 count_rejects
);

	localparam logic [PADDR_W-1:0] CAP_ADDR = {CAP_IDX, 2'b00};

	typedef struct packed {
		status_t           status;
		logic              has_data;
		logic [VAL_W-1:0]  read_value;
		logic [FILL_W-1:0] fill;
	} reply_t;

	// shadow copy of the stack and its capacity register
	logic [VAL_W-1:0] stack_mem [DEPTH];
	int unsigned      stack_occ;
	logic [CAP_W-1:0] capacity_reg;
	reply_t           stack_replies [$];

	// apply one command to the shadow stack and return the reply it gives
	function automatic reply_t run_stack_command(input logic [CMD_W-1:0] op,
			input logic [VAL_W-1:0] val, input logic [CNT_W-1:0] n);
		reply_t           r;
		int unsigned      cap_eff;
		int unsigned      top_idx;
		int unsigned      base_idx;
		int unsigned      i;
		logic [VAL_W-1:0] moved;
		r.status = ST_OK;
		r.has_data = 1'b0;
		r.read_value = '0;
		// zero acts as one, anything above the built depth as the depth
		cap_eff = capacity_reg;
		if (cap_eff < 1) cap_eff = 1;
		if (cap_eff > DEPTH) cap_eff = DEPTH;
		case (op)
			CMD_PUSH: begin
				if (stack_occ >= cap_eff) begin
					r.status = ST_FULL;
				end else begin
					stack_mem[stack_occ] = val;
					stack_occ++;
				end
			end
			CMD_POP, CMD_PEEK: begin
				if (stack_occ == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.read_value = stack_mem[stack_occ - 1];
					r.has_data = 1'b1;
					if (op == CMD_POP) stack_occ--;
				end
			end
			CMD_DUP: begin
				if (stack_occ == 0) begin
					r.status = ST_EMPTY;
				end else if (stack_occ >= cap_eff) begin
					r.status = ST_FULL;
				end else begin
					stack_mem[stack_occ] = stack_mem[stack_occ - 1];
					stack_occ++;
				end
			end
			CMD_ROT_UP, CMD_ROT_DOWN: begin
				if (n == 0 || n > stack_occ) begin
					r.status = ST_BADCOUNT;
				end else begin
					top_idx = stack_occ - 1;
					base_idx = stack_occ - n;
					if (op == CMD_ROT_UP) begin
						// top sinks to the n-th place, the rest rise
						moved = stack_mem[top_idx];
						for (i = top_idx; i > base_idx; i--) stack_mem[i] = stack_mem[i - 1];
						stack_mem[base_idx] = moved;
					end else begin
						// n-th place rises to the top, the rest sink
						moved = stack_mem[base_idx];
						for (i = base_idx; i < top_idx; i++) stack_mem[i] = stack_mem[i + 1];
						stack_mem[top_idx] = moved;
					end
				end
			end
			default: begin
			end
		endcase
		r.fill = stack_occ[FILL_W-1:0];
		return r;
	endfunction

	task automatic compare_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// watch the command, result and register channels
	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			stack_occ = 0;
			capacity_reg = CAP_RESET;
			stack_replies.delete();
			mismatches = 0;
			commands_seen = 0;
			results_checked = 0;
			full_reports = 0;
			empty_reports = 0;
			count_rejects = 0;
		end else begin
			// register write
			if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
				capacity_reg = pwdata[CAP_W-1:0];

			// accepted command item
			if (in_valid && !in_stall) begin
				want = run_stack_command(cmd, push_value, rotate_count);
				stack_replies.push_back(want);
				commands_seen++;
				case (want.status)
					ST_FULL:     full_reports++;
					ST_EMPTY:    empty_reports++;
					ST_BADCOUNT: count_rejects++;
					default: begin
					end
				endcase
			end

			// accepted result item
			if (out_valid && !out_stall) begin
				if (stack_replies.size() == 0) begin
					$error("result item with no command waiting for it");
					mismatches++;
				end else begin
					want = stack_replies.pop_front();
					compare_field("status", 8'(want.status), 8'(status));
					compare_field("has_data", 8'(want.has_data), 8'(has_data));
					compare_field("read_value", want.read_value, read_value);
					compare_field("fill", 8'(want.fill), 8'(fill));
					results_checked++;
				end
			end
		end
		outstanding = stack_replies.size();
		stack_fill = stack_occ;
	end

endmodule

// ----- tb/byte_stack_with_rotate_test.sv -----
`timescale 1ns / 100ps

module byte_stack_with_rotate_test;
	import bsr_pkg::*;

	localparam int STACK_DEPTH = 16;
	localparam int QUIET_LIMIT = 5000;
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
	localparam logic [PADDR_W-1:0] CAP_ADDR = {CAP_IDX, 2'b00};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [CMD_W-1:0]   cmd;
	logic [VAL_W-1:0]   push_value;
	logic [CNT_W-1:0]   rotate_count;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic               has_data;
	logic [VAL_W-1:0]   read_value;
	logic [FILL_W-1:0]  fill;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	int mismatches;
	int outstanding;
	int stack_fill;
	int commands_seen;
	int results_checked;
	int full_reports;
	int empty_reports;
	int count_rejects;

	int send_idle_pct;
	int stall_pct;
	int quiet_cycles;

	byte_stack_with_rotate #(.DEPTH(STACK_DEPTH)) uut (
		.clk, .arst_n,
		.in_valid, .in_stall, .cmd, .push_value, .rotate_count,
		.out_valid, .out_stall, .status, .has_data, .read_value, .fill,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	byte_stack_with_rotate_checker #(.DEPTH(STACK_DEPTH)) u_checker (
		.clk, .arst_n,
		.in_valid, .in_stall, .cmd, .push_value, .rotate_count,
		.out_valid, .out_stall, .status, .has_data, .read_value, .fill,
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.mismatches, .outstanding, .stack_fill, .commands_seen, .results_checked,
		.full_reports, .empty_reports, .count_rejects
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side stalls at random
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(99) < stall_pct);
		end
	end

	// watchdog on cycles where no item moves
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one command item, returning at the falling edge after it is taken
	task automatic send_item(input logic [CMD_W-1:0] op, input logic [VAL_W-1:0] val,
			input logic [CNT_W-1:0] n);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		cmd = op;
		push_value = val;
		rotate_count = n;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	// hold off until every result is back
	task automatic drain_results();
		in_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// capacity write, only with the block idle
	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		drain_results();
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = CAP_ADDR;
		pwdata = {27'($urandom), cap};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// random commands, leaning towards pushes by push_pct
	task automatic random_burst(input int count, input int push_pct);
		logic [CMD_W-1:0] op;
		logic [CNT_W-1:0] n;
		int unsigned      pick;
		int unsigned      fill_now;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(99);
			if (pick < push_pct) begin
				op = CMD_PUSH;
			end else begin
				pick = $urandom_range(99);
				if (pick < 22) op = CMD_POP;
				else if (pick < 36) op = CMD_PEEK;
				else if (pick < 50) op = CMD_DUP;
				else if (pick < 72) op = CMD_ROT_UP;
				else if (pick < 94) op = CMD_ROT_DOWN;
				else op = CMD_SPARE_LO + CMD_W'($urandom_range(CMD_SPARE_HI - CMD_SPARE_LO));
			end
			// mostly legal rotate counts, sometimes zero, one too many or anything
			fill_now = stack_fill;
			if (fill_now != 0 && $urandom_range(9) < 8) begin
				n = CNT_W'($urandom_range(fill_now, 1));
			end else begin
				case ($urandom_range(2))
					0: n = '0;
					1: n = CNT_W'(fill_now + 1);
					default: n = CNT_W'($urandom_range(255));
				endcase
			end
			send_item(op, VAL_W'($urandom_range(255)), n);
		end
	endtask

	initial begin
		int          seg_cap;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_PUSH;
		push_value = '0;
		rotate_count = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 7;
		stall_pct = 75;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty stack, spare codes, bad counts and rotates at full reach
		write_capacity(CAP_RESET);
		send_item(CMD_POP, 8'h00, 8'd0);
		send_item(CMD_PEEK, 8'h00, 8'd0);
		send_item(CMD_DUP, 8'h00, 8'd0);
		send_item(CMD_ROT_UP, 8'h00, 8'd0);
		send_item(CMD_ROT_DOWN, 8'h00, 8'd1);
		send_item(CMD_SPARE_LO, 8'hFF, 8'hFF);
		send_item(CMD_SPARE_HI, 8'h00, 8'd0);
		send_item(CMD_PUSH, 8'hFF, 8'd0);
		send_item(CMD_PUSH, 8'h00, 8'd0);
		send_item(CMD_PUSH, 8'hA5, 8'd0);
		send_item(CMD_DUP, 8'h00, 8'd0);
		send_item(CMD_PUSH, 8'h5A, 8'd0);
		send_item(CMD_ROT_UP, 8'h00, 8'd5);
		send_item(CMD_ROT_DOWN, 8'h00, 8'd5);
		send_item(CMD_ROT_UP, 8'h00, 8'd1);
		send_item(CMD_ROT_DOWN, 8'h00, 8'd3);
		send_item(CMD_ROT_UP, 8'h00, 8'd6);
		send_item(CMD_ROT_DOWN, 8'h00, 8'hFF);
		send_item(CMD_ROT_UP, 8'h00, 8'd0);
		send_item(CMD_PEEK, 8'h00, 8'd0);
		// capacity of zero acts as one and sits below the fill
		write_capacity(5'd0);
		send_item(CMD_PUSH, 8'h3C, 8'd0);
		send_item(CMD_DUP, 8'h00, 8'd0);
		send_item(CMD_POP, 8'h00, 8'd0);
		send_item(CMD_ROT_DOWN, 8'h00, 8'd2);
		write_capacity(5'd31);
		random_burst(20, 70);

		// three idling mixes, each with several capacity settings
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 7;
					stall_pct = 75;
				end
				1: begin
					send_idle_pct = 75;
					stall_pct = 7;
				end
				default: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 4; seg++) begin
				case (seg)
					0: seg_cap = 1;
					1: seg_cap = 17;
					default: seg_cap = $urandom_range(31);
				endcase
				write_capacity(CAP_W'(seg_cap));
				random_burst(40, (seg % 2 == 0) ? 20 : 60);
			end
		end

		// let the last results come back
		drain_results();
		repeat (20) @(negedge clk);

		$display("%0d command items sent, %0d results compared, capacities from 0 to 31",
			commands_seen, results_checked);
		$display("full %0d, empty %0d, rotate count rejected %0d, under three idling mixes",
			full_reports, empty_reports, count_rejects);
		if (mismatches == 0 && outstanding == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- byte_stack_with_rotate.f -----
+incdir+src
src/bsr_pkg.sv
src/bsr_ctrl.sv
src/bsr_dpath.sv
src/byte_stack_with_rotate.sv
tb/byte_stack_with_rotate_checker.sv
tb/byte_stack_with_rotate_test.sv
